/* src/assert_macros.svh */
// assertion macros for the checker module
// no dependencies; expects clk and rst_n in the using scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is held
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/ivt_pkg.sv */
// shared types and constants of the ip verdict table
// no dependencies
`default_nettype none

package ivt_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int ADDR_W            = 32;
  localparam int VERDICT_W         = 2;
  localparam int TICK_W            = 32;
  localparam int CMD_W             = 3;
  localparam int OUT_CNT_W         = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET   = 3'd0,
    CMD_TSET  = 3'd1,
    CMD_CLEAR = 3'd2,
    CMD_CHECK = 3'd3,
    CMD_TICK  = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0]    addr;
    logic [VERDICT_W-1:0] verdict;
    logic [TICK_W-1:0]    expiry;
  } entry_t;

endpackage

`default_nettype wire

/* src/ip_verdict_table_with_expiry_core.sv */
// top level of the ip verdict table with expiry
// depends on ivt_pkg
`default_nettype none

// Command-driven IPv4 verdict table. A transaction is accepted at a rising
// edge with start high and busy low; busy then stays high until the command
// is done. Each command then passes a scan, a drain and a commit state:
// the scan reads every table slot through the single read port of the
// entry memory, the drain waits out the registered read of the last slot,
// and the commit writes back and registers the result. The result then
// sits on the out_ ports for exactly one cycle, marked by out_valid, while
// busy is already low. The receiver cannot stall, so the result must be
// taken in that cycle. Every result carries the number of valid slots
// after the command. Slot contents live in a synchronous memory; only the
// valid bits are flops, cleared by reset.
module ip_verdict_table_with_expiry_core
  import ivt_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // command channel
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [CMD_W-1:0]      in_command,
  input  wire logic [ADDR_W-1:0]     in_ip_address,
  input  wire logic [VERDICT_W-1:0]  in_verdict,
  input  wire logic [TICK_W-1:0]     in_duration,
  input  wire logic [TICK_W-1:0]     in_current_tick,
  // result channel
  output logic                       out_valid,
  output logic                       out_accepted,
  output logic                       out_rule_found,
  output logic [VERDICT_W-1:0]       out_verdict_out,
  output logic [OUT_CNT_W-1:0]       out_entries_in_use
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // scan sequencer: read every slot, drain the read latency, then commit
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  state_t state_r, state_nxt;

  // slot contents, one synchronous read port and one write port
  entry_t mem [TABLE_ENTRIES];
  entry_t rd_data_r;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_wr_idx;
  entry_t                mem_wr_data;

  // valid bits and fill count
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;

  // read pipeline tracking
  logic [IDX_W-1:0] iss_idx_r, iss_idx_nxt;
  logic [IDX_W-1:0] rd_idx_r;
  logic             rd_vld_r;

  // latched command transaction
  logic [CMD_W-1:0]     cmd_r, cmd_nxt;
  logic [ADDR_W-1:0]    key_r, key_nxt;
  logic [VERDICT_W-1:0] verdict_r, verdict_nxt;
  logic [TICK_W-1:0]    dur_r, dur_nxt;
  logic [TICK_W-1:0]    now_r, now_nxt;

  // scan results: matching slot and lowest free slot
  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  entry_t           hit_ent_r, hit_ent_nxt;
  logic             free_r, free_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;

  // registered result
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_acc_r, out_acc_nxt;
  logic                 out_found_r, out_found_nxt;
  logic [VERDICT_W-1:0] out_verdict_r, out_verdict_nxt;
  logic [OUT_CNT_W-1:0] out_cnt_r, out_cnt_nxt;

  logic                 rd_slot_valid;
  logic [TICK_W-1:0]    exp_sum;
  logic                 is_timed;

  assign rd_slot_valid = valid_r[rd_idx_r];
  assign exp_sum       = now_r + dur_r;  // wraps mod 2^32; zero means permanent
  assign is_timed      = (cmd_r == CMD_TSET);

  always_comb begin
    state_nxt       = state_r;
    iss_idx_nxt     = iss_idx_r;
    valid_nxt       = valid_r;
    cnt_nxt         = cnt_r;
    cmd_nxt         = cmd_r;
    key_nxt         = key_r;
    verdict_nxt     = verdict_r;
    dur_nxt         = dur_r;
    now_nxt         = now_r;
    hit_nxt         = hit_r;
    hit_idx_nxt     = hit_idx_r;
    hit_ent_nxt     = hit_ent_r;
    free_nxt        = free_r;
    free_idx_nxt    = free_idx_r;
    out_valid_nxt   = 1'b0;
    out_acc_nxt     = out_acc_r;
    out_found_nxt   = out_found_r;
    out_verdict_nxt = out_verdict_r;
    mem_we          = 1'b0;
    mem_wr_idx      = hit_idx_r;
    mem_wr_data     = hit_ent_r;

    // compare stage: one slot's data arrives per cycle during the scan and the drain
    if (rd_vld_r) begin
      if (rd_slot_valid && rd_data_r.addr == key_r && !hit_r) begin
        hit_nxt     = 1'b1;
        hit_idx_nxt = rd_idx_r;
        hit_ent_nxt = rd_data_r;
      end
      if (!rd_slot_valid && !free_r) begin
        free_nxt     = 1'b1;
        free_idx_nxt = rd_idx_r;
      end
      // expiry sweep: at most one slot drops per cycle
      if (cmd_r == CMD_TICK && rd_slot_valid && rd_data_r.expiry != '0 &&
          now_r >= rd_data_r.expiry) begin
        valid_nxt[rd_idx_r] = 1'b0;
        cnt_nxt             = cnt_r - CNT_W'(1);
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt     = in_command;
          key_nxt     = in_ip_address;
          verdict_nxt = in_verdict;
          dur_nxt     = in_duration;
          now_nxt     = in_current_tick;
          hit_nxt     = 1'b0;
          free_nxt    = 1'b0;
          iss_idx_nxt = '0;
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (iss_idx_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end else begin
          iss_idx_nxt = iss_idx_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        out_valid_nxt   = 1'b1;
        out_acc_nxt     = 1'b0;
        out_found_nxt   = 1'b0;
        out_verdict_nxt = '0;
        state_nxt       = ST_IDLE;
        case (cmd_r)
          CMD_SET, CMD_TSET: begin
            if (hit_r) begin
              // existing rule: new verdict, expiry kept unless timed
              mem_we              = 1'b1;
              mem_wr_idx          = hit_idx_r;
              mem_wr_data.addr    = key_r;
              mem_wr_data.verdict = verdict_r;
              mem_wr_data.expiry  = is_timed ? exp_sum : hit_ent_r.expiry;
              out_acc_nxt         = 1'b1;
            end else if (free_r) begin
              // new rule in the lowest free slot, permanent unless timed
              mem_we                = 1'b1;
              mem_wr_idx            = free_idx_r;
              mem_wr_data.addr      = key_r;
              mem_wr_data.verdict   = verdict_r;
              mem_wr_data.expiry    = is_timed ? exp_sum : '0;
              valid_nxt[free_idx_r] = 1'b1;
              cnt_nxt               = cnt_r + CNT_W'(1);
              out_acc_nxt           = 1'b1;
            end
          end
          CMD_CLEAR: begin
            if (hit_r) begin
              valid_nxt[hit_idx_r] = 1'b0;
              cnt_nxt              = cnt_r - CNT_W'(1);
            end
          end
          CMD_CHECK: begin
            out_found_nxt   = hit_r;
            out_verdict_nxt = hit_r ? hit_ent_r.verdict : '0;
          end
          default: begin
            // tick already applied during the scan; unused codes do nothing
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_cnt_nxt = OUT_CNT_W'(cnt_nxt);
  end

  // control state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= (state_r == ST_SCAN);
      out_valid_r <= out_valid_nxt;
      hit_r       <= hit_nxt;
      free_r      <= free_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    iss_idx_r     <= iss_idx_nxt;
    rd_idx_r      <= iss_idx_r;
    cmd_r         <= cmd_nxt;
    key_r         <= key_nxt;
    verdict_r     <= verdict_nxt;
    dur_r         <= dur_nxt;
    now_r         <= now_nxt;
    hit_idx_r     <= hit_idx_nxt;
    hit_ent_r     <= hit_ent_nxt;
    free_idx_r    <= free_idx_nxt;
    out_acc_r     <= out_acc_nxt;
    out_found_r   <= out_found_nxt;
    out_verdict_r <= out_verdict_nxt;
    out_cnt_r     <= out_cnt_nxt;
  end

  // entry memory: reads every cycle but only scan reads are used, writes only at commit,
  // so a used read and a write of the same slot never overlap
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wr_idx] <= mem_wr_data;
    end
    rd_data_r <= mem[iss_idx_r];
  end

  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_accepted       = out_acc_r;
  assign out_rule_found     = out_found_r;
  assign out_verdict_out    = out_verdict_r;
  assign out_entries_in_use = out_cnt_r;

endmodule

`default_nettype wire

/* src/ivt_checker.sv */
// port-level checker for the ip verdict table, bound to the top level
// depends on ivt_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module ivt_checker
  import ivt_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic                 out_valid,
  input wire logic                 out_accepted,
  input wire logic                 out_rule_found,
  input wire logic [OUT_CNT_W-1:0] out_entries_in_use
);

  // an accepted command always makes the block busy
  `ASSERT_CLK(a_accept_busy, (start && !busy) |=> busy, "accept did not raise busy")

  // a result strobe lasts one cycle
  `ASSERT_CLK(a_strobe_pulse, out_valid |=> !out_valid, "result strobe held")

  // the result appears only once the command has finished
  `ASSERT_CLK(a_result_idle, out_valid |-> !busy, "result while busy")

  // the count never exceeds the table size
  `ASSERT_CLK(a_count_range, out_valid |-> (out_entries_in_use <= OUT_CNT_W'(TABLE_ENTRIES)),
              "entry count out of range")

  // a set result and a check result are never both reported
  `ASSERT_CLK(a_flags_excl, out_valid |-> !(out_accepted && out_rule_found),
              "accepted and rule_found both set")

endmodule

bind ip_verdict_table_with_expiry_core ivt_checker #(
  .TABLE_ENTRIES(TABLE_ENTRIES)
) u_ivt_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_accepted       (out_accepted),
  .out_rule_found     (out_rule_found),
  .out_entries_in_use (out_entries_in_use)
);

`default_nettype wire

/* tb/sv/tb_ip_verdict_table_with_expiry_core.sv */
// self-checking testbench for the ip verdict table with expiry
// depends on ivt_pkg and ip_verdict_table_with_expiry_core; a built-in table
// predictor checks every result transaction under random start gaps
module tb_ip_verdict_table_with_expiry_core
  import ivt_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = TABLE_ENTRIES_DEF;

  // command codes the block treats as no-ops
  localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;

  // random part: item count, phase length, address pool
  localparam int RAND_ITEMS = 600;
  localparam int PHASE_LEN  = 60;
  localparam int POOL_SIZE  = 24;

  // accepted-transaction window driven back to back, no gaps
  localparam int CALM_FIRST = 250;
  localparam int CALM_LAST  = 350;

  // one command transaction as it sits on the in_ ports
  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [ADDR_W-1:0]    addr;
    logic [VERDICT_W-1:0] verdict;
    logic [TICK_W-1:0]    duration;
    logic [TICK_W-1:0]    tick;
  } cmd_item_t;

  // one result transaction as seen on the out_ ports
  typedef struct packed {
    logic                 accepted;
    logic                 rule_found;
    logic [VERDICT_W-1:0] verdict;
    logic [OUT_CNT_W-1:0] in_use;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // everything the block reads is known from time zero
  logic                 start = 1'b0;
  logic [CMD_W-1:0]     in_command = '0;
  logic [ADDR_W-1:0]    in_ip_address = '0;
  logic [VERDICT_W-1:0] in_verdict = '0;
  logic [TICK_W-1:0]    in_duration = '0;
  logic [TICK_W-1:0]    in_current_tick = '0;

  logic                 busy;
  logic                 out_valid;
  logic                 out_accepted;
  logic                 out_rule_found;
  logic [VERDICT_W-1:0] out_verdict_out;
  logic [OUT_CNT_W-1:0] out_entries_in_use;

  ip_verdict_table_with_expiry_core #(
    .TABLE_ENTRIES(SLOTS)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_ip_address     (in_ip_address),
    .in_verdict        (in_verdict),
    .in_duration       (in_duration),
    .in_current_tick   (in_current_tick),
    .out_valid         (out_valid),
    .out_accepted      (out_accepted),
    .out_rule_found    (out_rule_found),
    .out_verdict_out   (out_verdict_out),
    .out_entries_in_use(out_entries_in_use)
  );

  // ---------------------------------------------------------------------
  // predicted table contents, same shape as the block's slots
  // ---------------------------------------------------------------------
  logic [ADDR_W-1:0]    slot_addr    [SLOTS];
  logic [VERDICT_W-1:0] slot_verdict [SLOTS];
  logic [TICK_W-1:0]    slot_expiry  [SLOTS];
  logic                 slot_valid   [SLOTS];

  cmd_item_t cmd_backlog[$];        // commands waiting for the driver
  reply_t    table_replies_due[$];  // predicted results, oldest first

  cmd_item_t on_ports;   // command currently presented with start
  reply_t    oldest_due;
  int        gap_left = 0;
  int        n_sent = 0;
  int        n_checked = 0;
  int        n_errors = 0;
  int        n_full_rejects = 0;
  int        n_aged_out = 0;
  int        n_lookup_hits = 0;

  logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
  logic [TICK_W-1:0] now_tick;

  // apply one command to the predicted table and return its result
  function automatic reply_t model_table_command(input cmd_item_t it);
    reply_t r;
    int     hit;
    int     slot;
    r    = '0;
    hit  = -1;
    slot = -1;
    // lowest valid slot with a matching address
    for (int i = 0; i < SLOTS; i++) begin
      if (hit < 0 && slot_valid[i] && slot_addr[i] == it.addr) hit = i;
    end
    case (it.cmd)
      CMD_SET, CMD_TSET: begin
        slot = hit;
        // new rule goes into the lowest free slot, permanent until timed
        if (slot < 0) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot < 0 && !slot_valid[i]) begin
              slot            = i;
              slot_addr[i]    = it.addr;
              slot_expiry[i]  = '0;
              slot_valid[i]   = 1'b1;
            end
          end
        end
        if (slot >= 0) begin
          slot_verdict[slot] = it.verdict;
          // expiry wraps mod 2^32; a sum of zero makes the rule permanent
          if (it.cmd == CMD_TSET) slot_expiry[slot] = it.tick + it.duration;
          r.accepted = 1'b1;
        end else begin
          n_full_rejects++;
        end
      end
      CMD_CLEAR: begin
        if (hit >= 0) slot_valid[hit] = 1'b0;
      end
      CMD_CHECK: begin
        if (hit >= 0) begin
          r.rule_found = 1'b1;
          r.verdict    = slot_verdict[hit];
          n_lookup_hits++;
        end
      end
      CMD_TICK: begin
        // age out timed rules whose expiry is at or before now
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_valid[i] && slot_expiry[i] != '0 && it.tick >= slot_expiry[i]) begin
            slot_valid[i] = 1'b0;
            n_aged_out++;
          end
        end
      end
      default: ;  // reserved codes only report the count
    endcase
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_valid[i]) r.in_use = r.in_use + 1'b1;
    end
    return r;
  endfunction

  task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                           input logic [VERDICT_W-1:0] verdict,
                           input logic [TICK_W-1:0] duration, input logic [TICK_W-1:0] tick);
    cmd_item_t it;
    it.cmd      = cmd;
    it.addr     = addr;
    it.verdict  = verdict;
    it.duration = duration;
    it.tick     = tick;
    cmd_backlog.push_back(it);
  endtask

  // random command, weighted by phase: 0 fills the table, 1 mixes, 2 drains it
  task automatic queue_random_cmd(input int phase);
    int                pick;
    int                sel;
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    logic [TICK_W-1:0] dur;
    logic [TICK_W-1:0] tick;
    pick = $urandom_range(0, 99);
    case (phase)
      0: sel = (pick < 45) ? 0 : (pick < 78) ? 1 : (pick < 85) ? 3 :
               (pick < 89) ? 2 : (pick < 97) ? 4 : 5;
      1: sel = (pick < 20) ? 0 : (pick < 40) ? 1 : (pick < 68) ? 3 :
               (pick < 82) ? 2 : (pick < 96) ? 4 : 5;
      default: sel = (pick < 8) ? 0 : (pick < 18) ? 1 : (pick < 42) ? 3 :
                     (pick < 75) ? 2 : (pick < 97) ? 4 : 5;
    endcase
    case (sel)
      0: cmd = CMD_SET;
      1: cmd = CMD_TSET;
      2: cmd = CMD_CLEAR;
      3: cmd = CMD_CHECK;
      4: cmd = CMD_TICK;
      default: cmd = CMD_W'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
    endcase
    // mostly pooled addresses so lookups and updates hit, some noise
    if ($urandom_range(0, 99) < 90) addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    else addr = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 80) dur = $urandom_range(1, 300);
    else if (pick < 90) dur = '0;
    else dur = $urandom;
    // time moves forward in small steps, with an occasional wild tick
    now_tick = now_tick + $urandom_range(0, 15);
    if ($urandom_range(0, 99) < 5) tick = $urandom;
    else tick = now_tick;
    queue_cmd(cmd, addr, VERDICT_W'($urandom_range(0, 3)), dur, tick);
  endtask

  // 4 ns clock
  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // driver: holds start until the transaction is taken, then maybe idles
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        // transaction accepted at this edge: predict its result now
        table_replies_due.push_back(model_table_command(on_ports));
        n_sent++;
        if (!(n_sent >= CALM_FIRST && n_sent < CALM_LAST) && $urandom_range(0, 99) < 38)
          gap_left = $urandom_range(1, 24);
        else
          gap_left = 0;
      end
      // ports are free when nothing is presented or it was just taken
      if (!start || !busy) begin
        if (gap_left != 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          on_ports        = cmd_backlog.pop_front();
          start           <= 1'b1;
          in_command      <= on_ports.cmd;
          in_ip_address   <= on_ports.addr;
          in_verdict      <= on_ports.verdict;
          in_duration     <= on_ports.duration;
          in_current_tick <= on_ports.tick;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // monitor: every strobed result is matched against the oldest prediction
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (table_replies_due.size() == 0) begin
        $display("%0t: result with none pending: accepted=%0b found=%0b verdict=%0d count=%0d",
                 $time, out_accepted, out_rule_found, out_verdict_out, out_entries_in_use);
        n_errors++;
      end else begin
        oldest_due = table_replies_due.pop_front();
        n_checked++;
        if (out_accepted !== oldest_due.accepted) begin
          $display("%0t: accepted expected %0b actual %0b",
                   $time, oldest_due.accepted, out_accepted);
          n_errors++;
        end
        if (out_rule_found !== oldest_due.rule_found) begin
          $display("%0t: rule_found expected %0b actual %0b",
                   $time, oldest_due.rule_found, out_rule_found);
          n_errors++;
        end
        if (out_verdict_out !== oldest_due.verdict) begin
          $display("%0t: verdict_out expected %0d actual %0d",
                   $time, oldest_due.verdict, out_verdict_out);
          n_errors++;
        end
        if (out_entries_in_use !== oldest_due.in_use) begin
          $display("%0t: entries_in_use expected %0d actual %0d",
                   $time, oldest_due.in_use, out_entries_in_use);
          n_errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------
  initial begin
    for (int i = 0; i < SLOTS; i++) slot_valid[i] = 1'b0;
    for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = $urandom;
    now_tick = $urandom;

    // directed: empty lookup, extreme addresses, update in place
    queue_cmd(CMD_CHECK, 32'h0000_0000, 2'd0, 32'd0, 32'd0);
    queue_cmd(CMD_SET,   32'h0000_0000, 2'd3, 32'd0, 32'd0);
    queue_cmd(CMD_SET,   32'hFFFF_FFFF, 2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_cmd(CMD_CHECK, 32'h0000_0000, 2'd0, 32'd0, 32'd0);
    queue_cmd(CMD_SET,   32'h0000_0000, 2'd1, 32'd0, 32'd0);
    queue_cmd(CMD_CHECK, 32'h0000_0000, 2'd2, 32'd0, 32'd0);
    // timed rules: max duration and tick, wrap to zero (permanent), short one
    queue_cmd(CMD_TSET,  32'hC0A8_0001, 2'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_cmd(CMD_TSET,  32'h0A00_0001, 2'd3, 32'h0000_0010, 32'hFFFF_FFF0);
    queue_cmd(CMD_TSET,  32'hAC10_0505, 2'd1, 32'd5, 32'd0);
    // plain set on a timed rule keeps its expiry
    queue_cmd(CMD_SET,   32'hAC10_0505, 2'd2, 32'd0, 32'd0);
    queue_cmd(CMD_TSET,  32'h7F00_0001, 2'd1, 32'd0, 32'd1234);
    queue_cmd(CMD_TICK,  32'd0, 2'd0, 32'd0, 32'd4);
    queue_cmd(CMD_TICK,  32'd0, 2'd0, 32'd0, 32'd5);
    queue_cmd(CMD_CHECK, 32'hAC10_0505, 2'd0, 32'd0, 32'd0);
    // clear of an absent address, then of a present one
    queue_cmd(CMD_CLEAR, 32'h0102_0304, 2'd0, 32'd0, 32'd0);
    queue_cmd(CMD_CLEAR, 32'hFFFF_FFFF, 2'd0, 32'd0, 32'd0);
    // reserved codes change nothing
    queue_cmd(CMD_RSVD_LO, 32'h0000_0000, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_cmd(CMD_RSVD_HI, 32'hC0A8_0001, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // latest tick ages out everything timed but the wrapped rule
    queue_cmd(CMD_TICK,  32'd0, 2'd0, 32'd0, 32'hFFFF_FFFF);
    queue_cmd(CMD_CHECK, 32'h0A00_0001, 2'd0, 32'd0, 32'd0);
    queue_cmd(CMD_TSET,  32'h0A00_0001, 2'd0, 32'd3, 32'd7);
    queue_cmd(CMD_TICK,  32'd0, 2'd0, 32'd0, 32'd10);
    queue_cmd(CMD_CHECK, 32'h0A00_0001, 2'd0, 32'd0, 32'd0);

    // random part in fill / mixed / drain phases
    for (int n = 0; n < RAND_ITEMS; n++) queue_random_cmd((n / PHASE_LEN) % 3);

    // synchronous reset, applied once
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // all commands taken, then all results in, then a drain window
    while (cmd_backlog.size() != 0 || start) @(posedge clk);
    while (table_replies_due.size() != 0) @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);

    $display("summary: %0d commands sent, %0d results checked, %0d lookup hits",
             n_sent, n_checked, n_lookup_hits);
    $display("summary: %0d table-full rejections, %0d rules aged out by tick",
             n_full_rejects, n_aged_out);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
